FILE: rtl/tcsni_pkg.sv
package tcsni_pkg;

  // Record and handshake constants
  localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
  localparam logic [15:0] FIXED_SKIP_LEN  = 16'd37;   // 3 length bytes + version + random
  localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
  localparam logic [15:0] NAME_HOST       = 16'h0000;
  localparam logic [15:0] SNL_HDR_LEN     = 16'd2;    // server name list length field
  localparam logic [15:0] ENT_HDR_LEN     = 16'd3;    // entry type + entry length
  localparam logic [15:0] EXT_HDR_LEN     = 16'd4;    // extension type + extension length

  localparam int unsigned OUT_DEPTH = 2;

  // Result status codes
  typedef enum logic [2:0] {
    ST_NAME       = 3'd0,
    ST_NAME_LAST  = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_FAIL       = 3'd3,
    ST_UNDECIDED  = 3'd4
  } status_t;

  // Parser phase, one-hot
  typedef enum logic [27:0] {
    PH_HDR_TYPE    = 28'h0000001,
    PH_HDR_VER1    = 28'h0000002,
    PH_HDR_VER2    = 28'h0000004,
    PH_HDR_LEN_HI  = 28'h0000008,
    PH_HDR_LEN_LO  = 28'h0000010,
    PH_HS_TYPE     = 28'h0000020,
    PH_FIXED_SKIP  = 28'h0000040,
    PH_SID_LEN     = 28'h0000080,
    PH_SID_SKIP    = 28'h0000100,
    PH_CS_LEN_HI   = 28'h0000200,
    PH_CS_LEN_LO   = 28'h0000400,
    PH_CS_SKIP     = 28'h0000800,
    PH_CM_LEN      = 28'h0001000,
    PH_CM_SKIP     = 28'h0002000,
    PH_EXTS_LEN_HI = 28'h0004000,
    PH_EXTS_LEN_LO = 28'h0008000,
    PH_EXT_TYPE_HI = 28'h0010000,
    PH_EXT_TYPE_LO = 28'h0020000,
    PH_EXT_LEN_HI  = 28'h0040000,
    PH_EXT_LEN_LO  = 28'h0080000,
    PH_EXT_SKIP    = 28'h0100000,
    PH_SNL_SKIP    = 28'h0200000,
    PH_ENT_TYPE    = 28'h0400000,
    PH_ENT_LEN_HI  = 28'h0800000,
    PH_ENT_LEN_LO  = 28'h1000000,
    PH_ENT_SKIP    = 28'h2000000,
    PH_NAME        = 28'h4000000,
    PH_DONE        = 28'h8000000
  } phase_t;

  // Phase groups
  localparam logic [27:0] MASK_EXT_LIST = 28'h3FF0000;  // extension type high .. entry skip
  localparam logic [27:0] MASK_EXT_BODY = 28'h3F00000;  // extension skip .. entry skip
  localparam logic [27:0] MASK_BODY     = 28'h7FFFFE0;  // handshake type .. name

  typedef struct packed {
    logic [7:0] name_byte;
    status_t    status;
  } result_t;

endpackage

FILE: rtl/tcsni_core.sv
module tcsni_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        payload_byte,
  input  logic              flow_start,
  input  logic              segment_last,
  output logic              res_valid,
  output tcsni_pkg::result_t res
);
  import tcsni_pkg::*;

  phase_t      parse_phase, parse_phase_next;
  logic [15:0] record_length, record_length_next;
  logic [15:0] record_offset, record_offset_next;
  logic [15:0] skip_count, skip_count_next;
  logic [15:0] extensions_left, extensions_left_next;
  logic [15:0] extension_type, extension_type_next;
  logic [15:0] extension_left, extension_left_next;
  logic [7:0]  length_high_byte, length_high_byte_next;
  logic        decided, decided_next;

  always_comb begin
    phase_t      ph;
    logic [15:0] w;
    logic [15:0] clip;
    logic [16:0] name_end;
    logic        skip_zero;
    logic        want_entry;
    logic        want_next;
    logic        fail;

    // flow start restarts the parser before the byte is taken
    ph                    = flow_start ? PH_HDR_TYPE : parse_phase;
    parse_phase_next      = ph;
    record_length_next    = flow_start ? 16'd0 : record_length;
    record_offset_next    = flow_start ? 16'd0 : record_offset;
    skip_count_next       = flow_start ? 16'd0 : skip_count;
    extensions_left_next  = flow_start ? 16'd0 : extensions_left;
    extension_type_next   = flow_start ? 16'd0 : extension_type;
    extension_left_next   = flow_start ? 16'd0 : extension_left;
    length_high_byte_next = flow_start ? 8'd0  : length_high_byte;
    decided_next          = flow_start ? 1'b0  : decided;

    w          = {length_high_byte_next, payload_byte};
    clip       = 16'd0;
    name_end   = 17'd0;
    want_entry = 1'b0;
    want_next  = 1'b0;
    fail       = 1'b0;
    res_valid  = 1'b0;
    res.name_byte = 8'd0;
    res.status    = ST_NAME;

    // shared skip counter step
    if (skip_count_next != 16'd0) begin
      skip_count_next = skip_count_next - 16'd1;
    end
    skip_zero = (skip_count_next == 16'd0);
    // the decrement is only kept in skip phases; others overwrite or restore below
    if (!(ph == PH_FIXED_SKIP || ph == PH_SID_SKIP || ph == PH_CS_SKIP ||
          ph == PH_CM_SKIP || ph == PH_SNL_SKIP || ph == PH_ENT_SKIP || ph == PH_NAME)) begin
      skip_count_next = flow_start ? 16'd0 : skip_count;
    end

    if ((logic'(|(ph & MASK_BODY)))) begin
      record_offset_next = record_offset_next + 16'd1;
      if ((|(ph & MASK_EXT_LIST)) && extensions_left_next != 16'd0) begin
        extensions_left_next = extensions_left_next - 16'd1;
      end
      if ((|(ph & MASK_EXT_BODY)) && extension_left_next != 16'd0) begin
        extension_left_next = extension_left_next - 16'd1;
      end
    end

    unique case (ph) inside
      PH_HDR_TYPE: begin
        if (payload_byte != REC_HANDSHAKE) fail = 1'b1;
        else parse_phase_next = PH_HDR_VER1;
      end
      PH_HDR_VER1: parse_phase_next = PH_HDR_VER2;
      PH_HDR_VER2: parse_phase_next = PH_HDR_LEN_HI;
      PH_HDR_LEN_HI: begin
        length_high_byte_next = payload_byte;
        parse_phase_next      = PH_HDR_LEN_LO;
      end
      PH_HDR_LEN_LO: begin
        record_length_next = w;
        record_offset_next = 16'd0;
        parse_phase_next   = PH_HS_TYPE;
      end
      PH_HS_TYPE: begin
        if (payload_byte != HS_CLIENT_HELLO) begin
          fail = 1'b1;
        end else begin
          skip_count_next  = FIXED_SKIP_LEN;
          parse_phase_next = PH_FIXED_SKIP;
        end
      end
      PH_FIXED_SKIP: if (skip_zero) parse_phase_next = PH_SID_LEN;
      PH_SID_LEN: begin
        if (payload_byte == 8'd0) begin
          parse_phase_next = PH_CS_LEN_HI;
        end else begin
          skip_count_next  = {8'd0, payload_byte};
          parse_phase_next = PH_SID_SKIP;
        end
      end
      PH_SID_SKIP: if (skip_zero) parse_phase_next = PH_CS_LEN_HI;
      PH_CS_LEN_HI, PH_EXTS_LEN_HI, PH_EXT_TYPE_HI, PH_EXT_LEN_HI, PH_ENT_LEN_HI: begin
        length_high_byte_next = payload_byte;
        parse_phase_next      = phase_t'({ph[26:0], 1'b0});
      end
      PH_CS_LEN_LO: begin
        if (w == 16'd0) begin
          parse_phase_next = PH_CM_LEN;
        end else begin
          skip_count_next  = w;
          parse_phase_next = PH_CS_SKIP;
        end
      end
      PH_CS_SKIP: if (skip_zero) parse_phase_next = PH_CM_LEN;
      PH_CM_LEN: begin
        if (payload_byte == 8'd0) begin
          parse_phase_next = PH_EXTS_LEN_HI;
        end else begin
          skip_count_next  = {8'd0, payload_byte};
          parse_phase_next = PH_CM_SKIP;
        end
      end
      PH_CM_SKIP: if (skip_zero) parse_phase_next = PH_EXTS_LEN_HI;
      PH_EXTS_LEN_LO: begin
        extensions_left_next = w;
        want_next            = 1'b1;
      end
      PH_EXT_TYPE_LO: begin
        extension_type_next = w;
        parse_phase_next    = PH_EXT_LEN_HI;
      end
      PH_EXT_LEN_LO: begin
        extension_left_next = w;
        if (extension_type_next == EXT_SERVER_NAME && w >= SNL_HDR_LEN) begin
          skip_count_next  = SNL_HDR_LEN;
          parse_phase_next = PH_SNL_SKIP;
        end else if (w == 16'd0) begin
          want_next = 1'b1;
        end else begin
          parse_phase_next = PH_EXT_SKIP;
        end
      end
      PH_EXT_SKIP: if (extension_left_next == 16'd0) want_next = 1'b1;
      PH_SNL_SKIP, PH_ENT_SKIP: if (skip_zero) want_entry = 1'b1;
      PH_ENT_TYPE: begin
        extension_type_next = {8'd0, payload_byte};
        parse_phase_next    = PH_ENT_LEN_HI;
      end
      PH_ENT_LEN_LO: begin
        if (extension_type_next == NAME_HOST) begin
          name_end = {1'b0, record_offset_next} + {1'b0, w};
          if (name_end > {1'b0, record_length_next}) begin
            fail = 1'b1;
          end else if (w == 16'd0) begin
            decided_next     = 1'b1;
            parse_phase_next = PH_DONE;
            res_valid        = 1'b1;
            res.status       = ST_EMPTY;
          end else begin
            decided_next     = 1'b1;
            skip_count_next  = w;
            parse_phase_next = PH_NAME;
          end
        end else begin
          clip = (w < extension_left_next) ? w : extension_left_next;
          if (clip == 16'd0) begin
            want_entry = 1'b1;
          end else begin
            skip_count_next  = clip;
            parse_phase_next = PH_ENT_SKIP;
          end
        end
      end
      PH_NAME: begin
        res_valid     = 1'b1;
        res.name_byte = payload_byte;
        if (skip_zero) begin
          parse_phase_next = PH_DONE;
          res.status       = ST_NAME_LAST;
        end else begin
          res.status = ST_NAME;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    // next entry header, or end of this extension
    if (want_entry) begin
      if (extension_left_next >= ENT_HDR_LEN) begin
        parse_phase_next = PH_ENT_TYPE;
      end else if (extension_left_next == 16'd0) begin
        want_next = 1'b1;
      end else begin
        parse_phase_next = PH_EXT_SKIP;
      end
    end

    // next extension header needs four bytes of the list
    if (want_next) begin
      if (extensions_left_next < EXT_HDR_LEN) fail = 1'b1;
      else parse_phase_next = PH_EXT_TYPE_HI;
    end

    // record end reached with nothing decided
    if (!fail && !res_valid && !decided_next && (|(parse_phase_next & MASK_BODY)) &&
        record_offset_next >= record_length_next) begin
      fail = 1'b1;
    end

    if (fail) begin
      decided_next     = 1'b1;
      parse_phase_next = PH_DONE;
      res_valid        = 1'b1;
      res.name_byte    = 8'd0;
      res.status       = ST_FAIL;
    end else if (!res_valid && !decided_next && segment_last) begin
      res_valid     = 1'b1;
      res.name_byte = 8'd0;
      res.status    = ST_UNDECIDED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_HDR_TYPE;
      record_length    <= 16'd0;
      record_offset    <= 16'd0;
      skip_count       <= 16'd0;
      extensions_left  <= 16'd0;
      extension_type   <= 16'd0;
      extension_left   <= 16'd0;
      length_high_byte <= 8'd0;
      decided          <= 1'b0;
    end else if (accept) begin
      parse_phase      <= parse_phase_next;
      record_length    <= record_length_next;
      record_offset    <= record_offset_next;
      skip_count       <= skip_count_next;
      extensions_left  <= extensions_left_next;
      extension_type   <= extension_type_next;
      extension_left   <= extension_left_next;
      length_high_byte <= length_high_byte_next;
      decided          <= decided_next;
    end
  end

endmodule

FILE: rtl/tcsni_outq.sv
module tcsni_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  tcsni_pkg::result_t wr_data,
  output logic               space,
  output logic               valid,
  input  logic               ready,
  output tcsni_pkg::result_t rd_data
);
  import tcsni_pkg::*;

  result_t    mem [OUT_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count, count_next;
  logic       rd;

  assign valid   = (count != 2'd0);
  assign space   = (count != 2'(OUT_DEPTH));
  assign rd      = valid && ready;
  assign rd_data = mem[rd_ptr];

  always_comb begin
    count_next = count;
    case ({wr, rd})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      count <= count_next;
    end
  end

endmodule

FILE: rtl/tls_client_hello_sni_parser.sv
// TLS ClientHello server-name extractor for one TCP flow.
// Slave side: one payload byte per word. s_tuser marks the first byte of a
// new flow (the parser restarts before taking it), s_tlast marks the last
// byte of a delivered segment.
// Master side: zero or one result word per payload byte. m_tdata carries a
// host-name byte, m_tuser the status: 0 name byte, 1 final name byte,
// 2 empty name, 3 failed, 4 segment ended undecided.
// Each byte is handled in the cycle it is accepted; its result word is
// registered into the result queue. One byte per cycle is sustained
// as long as results are drained; the two-word result queue sets how far
// the receiver may fall behind before s_tready drops.
// Reset: parser waits for a record header, result queue is empty.
// When m_tready is held low the queue fills and s_tready falls; no word is
// lost and the parser state stays put until bytes flow again.
module tls_client_hello_sni_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] payload_byte
  input  logic       s_tuser,   // [0] flow_start
  input  logic       s_tlast,   // segment_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] name_byte
  output logic [2:0] m_tuser    // [2:0] status
);
  import tcsni_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t head;
  logic    space;

  // a byte is taken only when the queue can hold its possible result
  assign s_tready = space;
  assign accept   = s_tvalid && s_tready;

  tcsni_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .payload_byte (s_tdata),
    .flow_start   (s_tuser),
    .segment_last (s_tlast),
    .res_valid    (res_valid),
    .res          (res)
  );

  tcsni_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept && res_valid),
    .wr_data (res),
    .space   (space),
    .valid   (m_tvalid),
    .ready   (m_tready),
    .rd_data (head)
  );

  assign m_tdata = head.name_byte;
  assign m_tuser = head.status;

endmodule

FILE: test/tls_client_hello_sni_parser_tb.sv
`timescale 1ns / 1ps

module tls_client_hello_sni_parser_tb;
  import tcsni_pkg::*;

  localparam int SENT_BYTES      = 750;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int DIR_ROWS        = 25;

  // Flow shapes for the random part
  typedef enum int {
    FK_GOOD, FK_EMPTY_NAME, FK_NO_HOST, FK_NO_SNI, FK_SHORT_SNI,
    FK_NAME_OVERRUN, FK_TRUNC, FK_BAD_TYPE, FK_BAD_HS, FK_NOISE, FK_COUNT
  } flow_kind_t;

  // One directed word; has/st are only used where typed is set
  typedef struct packed {
    logic [7:0] pb;
    logic       fs;
    logic       sl;
    logic       typed;
    logic       has;
    status_t    st;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] payload_byte
  logic       s_tuser;   // [0] flow_start
  logic       s_tlast;   // segment_last
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] name_byte
  logic [2:0] m_tuser;   // [2:0] status

  tls_client_hello_sni_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Predicted parser state
  phase_t      pr_phase;
  logic [15:0] pr_rec_len;
  logic [15:0] pr_rec_off;
  logic [15:0] pr_skip;
  logic [15:0] pr_exts_left;
  logic [15:0] pr_ext_type;
  logic [15:0] pr_ext_left;
  logic [7:0]  pr_len_hi;
  logic        pr_decided;

  result_t     sni_results_q[$];
  logic [7:0]  flow_q[$];

  int          err_count = 0;
  int          sent_bytes = 0;
  int          flows_sent = 0;
  int          words_by_status [0:7];
  int          stall_cycles = 0;

  // Stimulus side controls
  bit          row_typed = 1'b0;
  bit          row_has;
  status_t     row_status;
  bit          tx_steady = 1'b0;
  int          burst_left = 0;
  int          rx_mode = 0;
  int          rx_cycle = 0;
  bit          hold_off_req = 1'b0;

  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1, ST_FAIL},       // not a handshake record
    '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, ST_NAME},       // decided: ignored
    '{8'h16, 1'b1, 1'b1, 1'b1, 1'b1, ST_UNDECIDED},
    '{8'h03, 1'b0, 1'b0, 1'b1, 1'b0, ST_NAME},
    '{8'h01, 1'b0, 1'b1, 1'b1, 1'b1, ST_UNDECIDED},
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, ST_NAME},
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, ST_FAIL},       // empty record
    '{8'h16, 1'b1, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'h03, 1'b0, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'h03, 1'b0, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, ST_NAME},       // record length max
    '{8'h02, 1'b0, 1'b0, 1'b1, 1'b1, ST_FAIL},       // not a ClientHello
    '{8'h16, 1'b1, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'h03, 1'b0, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'h03, 1'b0, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'h01, 1'b0, 1'b0, 1'b1, 1'b1, ST_FAIL},       // record ends after type
    '{8'h16, 1'b1, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'h03, 1'b0, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'h30, 1'b0, 1'b0, 1'b0, 1'b0, ST_NAME},
    '{8'h01, 1'b0, 1'b1, 1'b1, 1'b1, ST_UNDECIDED}   // mid fixed skip
  };

  // ---------------------------------------------------------------- predictor

  function automatic void sni_flow_restart();
    pr_phase     = PH_HDR_TYPE;
    pr_rec_len   = '0;
    pr_rec_off   = '0;
    pr_skip      = '0;
    pr_exts_left = '0;
    pr_ext_type  = '0;
    pr_ext_left  = '0;
    pr_len_hi    = '0;
    pr_decided   = 1'b0;
  endfunction

  function automatic int sni_fail();
    pr_decided = 1'b1;
    pr_phase   = PH_DONE;
    return ST_FAIL;
  endfunction

  function automatic bit skip_ends();
    if (pr_skip != 0) pr_skip = pr_skip - 16'd1;
    return pr_skip == 0;
  endfunction

  function automatic void skip_or_go(input logic [15:0] n, input phase_t skip_ph,
                                     input phase_t next_ph);
    if (n == 0) begin
      pr_phase = next_ph;
    end else begin
      pr_skip  = n;
      pr_phase = skip_ph;
    end
  endfunction

  // needs a full extension header left in the list, else no host name
  function automatic int next_ext_or_fail();
    if (pr_exts_left < EXT_HDR_LEN) return sni_fail();
    pr_phase = PH_EXT_TYPE_HI;
    return -1;
  endfunction

  function automatic int entry_or_ext_end();
    if (pr_ext_left >= ENT_HDR_LEN) begin
      pr_phase = PH_ENT_TYPE;
      return -1;
    end
    if (pr_ext_left == 0) return next_ext_or_fail();
    pr_phase = PH_EXT_SKIP;
    return -1;
  endfunction

  // Bytes after the record header; offsets count from the handshake type
  function automatic int sni_body_byte(input logic [7:0] b, output logic [7:0] nb);
    phase_t      ph;
    logic [15:0] w;
    int          code;
    ph   = pr_phase;
    code = -1;
    nb   = 8'h00;
    w    = {pr_len_hi, b};
    pr_rec_off = pr_rec_off + 16'd1;
    if ((ph & MASK_EXT_LIST) != 0 && pr_exts_left != 0) pr_exts_left = pr_exts_left - 16'd1;
    if ((ph & MASK_EXT_BODY) != 0 && pr_ext_left != 0) pr_ext_left = pr_ext_left - 16'd1;
    case (ph) inside
      PH_HS_TYPE: begin
        if (b != HS_CLIENT_HELLO) code = sni_fail();
        else skip_or_go(FIXED_SKIP_LEN, PH_FIXED_SKIP, PH_SID_LEN);
      end
      PH_FIXED_SKIP: if (skip_ends()) pr_phase = PH_SID_LEN;
      PH_SID_LEN:    skip_or_go({8'h00, b}, PH_SID_SKIP, PH_CS_LEN_HI);
      PH_SID_SKIP:   if (skip_ends()) pr_phase = PH_CS_LEN_HI;
      PH_CS_LEN_HI, PH_EXTS_LEN_HI, PH_EXT_TYPE_HI, PH_EXT_LEN_HI, PH_ENT_LEN_HI: begin
        pr_len_hi = b;
        pr_phase  = phase_t'({ph[26:0], 1'b0});
      end
      PH_CS_LEN_LO:  skip_or_go(w, PH_CS_SKIP, PH_CM_LEN);
      PH_CS_SKIP:    if (skip_ends()) pr_phase = PH_CM_LEN;
      PH_CM_LEN:     skip_or_go({8'h00, b}, PH_CM_SKIP, PH_EXTS_LEN_HI);
      PH_CM_SKIP:    if (skip_ends()) pr_phase = PH_EXTS_LEN_HI;
      PH_EXTS_LEN_LO: begin
        pr_exts_left = w;
        code = next_ext_or_fail();
      end
      PH_EXT_TYPE_LO: begin
        pr_ext_type = w;
        pr_phase    = PH_EXT_LEN_HI;
      end
      PH_EXT_LEN_LO: begin
        pr_ext_left = w;
        if (pr_ext_type == EXT_SERVER_NAME && w >= SNL_HDR_LEN) begin
          pr_skip  = SNL_HDR_LEN;
          pr_phase = PH_SNL_SKIP;
        end else if (w == 0) begin
          code = next_ext_or_fail();
        end else begin
          pr_phase = PH_EXT_SKIP;
        end
      end
      PH_EXT_SKIP: if (pr_ext_left == 0) code = next_ext_or_fail();
      PH_SNL_SKIP, PH_ENT_SKIP: if (skip_ends()) code = entry_or_ext_end();
      PH_ENT_TYPE: begin
        pr_ext_type = {8'h00, b};
        pr_phase    = PH_ENT_LEN_HI;
      end
      PH_ENT_LEN_LO: begin
        if (pr_ext_type == NAME_HOST) begin
          // host name must fit in the record
          if ((17'(pr_rec_off) + 17'(w)) > 17'(pr_rec_len)) begin
            code = sni_fail();
          end else begin
            pr_decided = 1'b1;
            if (w == 0) begin
              pr_phase = PH_DONE;
              code     = ST_EMPTY;
            end else begin
              pr_skip  = w;
              pr_phase = PH_NAME;
            end
          end
        end else begin
          // other entry types: skip, clipped to the extension end
          if (w > pr_ext_left) w = pr_ext_left;
          if (w == 0) begin
            code = entry_or_ext_end();
          end else begin
            pr_skip  = w;
            pr_phase = PH_ENT_SKIP;
          end
        end
      end
      PH_NAME: begin
        nb = b;
        if (skip_ends()) begin
          pr_phase = PH_DONE;
          code     = ST_NAME_LAST;
        end else begin
          code = ST_NAME;
        end
      end
      default: ;
    endcase
    return code;
  endfunction

  function automatic void sni_parse_byte(input logic [7:0] b, input bit fs, input bit sl,
                                         output bit has, output result_t res);
    logic [7:0] nb;
    int         code;
    nb   = 8'h00;
    code = -1;
    if (fs) sni_flow_restart();
    case (pr_phase)
      PH_HDR_TYPE: begin
        if (b != REC_HANDSHAKE) code = sni_fail();
        else pr_phase = PH_HDR_VER1;
      end
      PH_HDR_VER1:   pr_phase = PH_HDR_VER2;
      PH_HDR_VER2:   pr_phase = PH_HDR_LEN_HI;
      PH_HDR_LEN_HI: begin
        pr_len_hi = b;
        pr_phase  = PH_HDR_LEN_LO;
      end
      PH_HDR_LEN_LO: begin
        pr_rec_len = {pr_len_hi, b};
        pr_rec_off = '0;
        pr_phase   = PH_HS_TYPE;
      end
      PH_DONE: ;
      default: code = sni_body_byte(b, nb);
    endcase
    // reached the record end with nothing decided
    if (code < 0 && !pr_decided && (pr_phase & MASK_BODY) != 0 && pr_rec_off >= pr_rec_len)
      code = sni_fail();
    if (code < 0 && !pr_decided && sl) code = ST_UNDECIDED;
    has           = (code >= 0);
    res.name_byte = (code >= 0 && code <= ST_NAME_LAST) ? nb : 8'h00;
    res.status    = status_t'(code[2:0]);
  endfunction

  // ---------------------------------------------------------- flow builder

  function automatic void put16(ref logic [7:0] q[$], input logic [15:0] v);
    q.push_back(v[15:8]);
    q.push_back(v[7:0]);
  endfunction

  function automatic void put_rand(ref logic [7:0] q[$], input int n);
    repeat (n) q.push_back(8'($urandom));
  endfunction

  function automatic void put_other_ext(ref logic [7:0] q[$]);
    int n;
    n = $urandom_range(0, 6);
    put16(q, 16'($urandom_range(1, 65535)));
    put16(q, 16'(n));
    put_rand(q, n);
  endfunction

  function automatic void build_flow(input flow_kind_t kind);
    logic [7:0] body[$];
    logic [7:0] exts[$];
    logic [7:0] ents[$];
    int         n;
    int         name_len;
    int         rec_len;
    flow_q.delete();
    if (kind == FK_NOISE) begin
      put_rand(flow_q, $urandom_range(1, 8));
      if ($urandom_range(0, 1) == 1) flow_q[0] = REC_HANDSHAKE;
      return;
    end
    name_len = 0;
    repeat ($urandom_range(0, 2)) put_other_ext(exts);
    if (kind != FK_NO_SNI) begin
      if (kind == FK_SHORT_SNI) begin
        // server name extension too short for a list length
        n = $urandom_range(0, 1);
        put16(exts, EXT_SERVER_NAME);
        put16(exts, 16'(n));
        put_rand(exts, n);
      end
      if (kind == FK_NO_HOST || $urandom_range(0, 3) == 0) begin
        n = $urandom_range(0, 4);
        ents.push_back(8'($urandom_range(1, 255)));
        if (kind == FK_NO_HOST && $urandom_range(0, 2) == 0)
          put16(ents, 16'hFF00 | 16'($urandom_range(0, 255)));
        else
          put16(ents, 16'(n));
        put_rand(ents, n);
      end
      if (kind == FK_NO_HOST) begin
        put_rand(ents, $urandom_range(0, 2));   // too short for an entry header
      end else begin
        if (kind == FK_EMPTY_NAME) name_len = 0;
        else if ($urandom_range(0, 7) == 0) name_len = $urandom_range(13, 64);
        else name_len = $urandom_range(1, 12);
        ents.push_back(NAME_HOST[7:0]);
        put16(ents, 16'(name_len));
        put_rand(ents, name_len);
      end
      put16(exts, EXT_SERVER_NAME);
      put16(exts, 16'(ents.size() + 2));
      put16(exts, 16'(ents.size()));
      foreach (ents[j]) exts.push_back(ents[j]);
    end
    repeat ($urandom_range(0, 1)) put_other_ext(exts);
    if (kind == FK_NO_HOST || kind == FK_NO_SNI) put_rand(exts, $urandom_range(0, 3));

    if (kind == FK_BAD_HS)
      body.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(2, 255)));
    else
      body.push_back(HS_CLIENT_HELLO);
    put_rand(body, FIXED_SKIP_LEN);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : 0;
    body.push_back(8'(n));
    put_rand(body, n);
    n = 2 * $urandom_range(0, 5);
    put16(body, 16'(n));
    put_rand(body, n);
    n = $urandom_range(0, 2);
    body.push_back(8'(n));
    put_rand(body, n);
    put16(body, 16'(exts.size()));
    foreach (exts[j]) body.push_back(exts[j]);

    rec_len = body.size();
    case (kind) inside
      FK_TRUNC:        rec_len = $urandom_range(1, body.size() - 1);
      FK_NAME_OVERRUN: rec_len = body.size() - $urandom_range(1, name_len);
      FK_NO_HOST, FK_NO_SNI: rec_len = rec_len + $urandom_range(1, 8);
      default: if ($urandom_range(0, 3) == 0) rec_len = rec_len + $urandom_range(1, 4);
    endcase

    if (kind == FK_BAD_TYPE) begin
      n = $urandom_range(0, 255);
      flow_q.push_back((n == REC_HANDSHAKE) ? 8'h17 : 8'(n));
    end else begin
      flow_q.push_back(REC_HANDSHAKE);
    end
    flow_q.push_back(8'h03);
    flow_q.push_back(8'($urandom));
    put16(flow_q, 16'(rec_len));
    foreach (body[j]) flow_q.push_back(body[j]);
    put_rand(flow_q, $urandom_range(0, 3));   // trailing bytes after the decision
    // now and then the next flow starts mid-parse
    if (kind == FK_GOOD && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, flow_q.size() - 1);
      while (flow_q.size() > n) void'(flow_q.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------- driving

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer(input logic [7:0] pb, input bit fs, input bit sl);
    int gap;
    if (!tx_steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pb;
    s_tuser  <= fs;
    s_tlast  <= sl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (burst_left != 0) burst_left--;
  endtask

  task automatic idle_until_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sni_results_q.size() != 0) @(negedge clk);
  endtask

  // receiver: own stall pattern, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          2:       m_tready <= ((rx_cycle % 5) < 3);
          default: m_tready <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  // ------------------------------------------------------ monitor and check

  always @(posedge clk) begin : mon_b
    bit      has;
    result_t want;
    result_t pred;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sent_bytes++;
        sni_parse_byte(s_tdata, s_tuser, s_tlast, has, pred);
        if (row_typed) begin
          has            = row_has;
          pred.name_byte = 8'h00;
          pred.status    = row_status;
        end
        if (has) sni_results_q.push_back(pred);
      end
      if (m_tvalid && m_tready) begin
        words_by_status[m_tuser]++;
        if (sni_results_q.size() == 0) begin
          $error("unexpected result word: name_byte %0d status %0d", m_tdata, m_tuser);
          err_count++;
        end else begin
          want = sni_results_q.pop_front();
          if (m_tdata !== want.name_byte) begin
            $error("name_byte: expected %0d, got %0d", want.name_byte, m_tdata);
            err_count++;
          end
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            err_count++;
          end
        end
      end
    end
  end

  // watchdog: no word moving on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
      $display("tls_client_hello_sni_parser_tb failed");
      $finish;
    end
  end

  // ------------------------------------------------------------- stimulus

  initial begin : stim_b
    int         idx;
    flow_kind_t kind;
    bit         held;
    held     = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = 1'b0;
    s_tlast  = 1'b0;
    foreach (words_by_status[j]) words_by_status[j] = 0;
    sni_flow_restart();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words
    rx_mode = 1;
    foreach (dir_rows[j]) begin
      row_typed  = dir_rows[j].typed;
      row_has    = dir_rows[j].has;
      row_status = dir_rows[j].st;
      offer(dir_rows[j].pb, dir_rows[j].fs, dir_rows[j].sl);
    end
    row_typed = 1'b0;

    // every flow shape once, then a weighted mix
    idx = 0;
    while (idx < FK_COUNT || sent_bytes < SENT_BYTES) begin
      if (idx < FK_COUNT) begin
        kind = flow_kind_t'(idx);
      end else begin
        case ($urandom_range(0, 19))
          9:       kind = FK_EMPTY_NAME;
          10:      kind = FK_NO_HOST;
          11:      kind = FK_NO_SNI;
          12:      kind = FK_SHORT_SNI;
          13:      kind = FK_NAME_OVERRUN;
          14:      kind = FK_TRUNC;
          15:      kind = FK_BAD_TYPE;
          16:      kind = FK_BAD_HS;
          17:      kind = FK_NOISE;
          default: kind = FK_GOOD;
        endcase
      end
      if (idx % 4 == 2) begin
        rx_mode   = 0;
        tx_steady = 1'b1;
      end else begin
        rx_mode   = $urandom_range(0, 3);
        tx_steady = ($urandom_range(0, 3) == 0);
      end
      // long receiver hold-off over a full name: result queue fills, input stalls
      if (kind == FK_GOOD && !held) begin
        hold_off_req = 1'b1;
        held         = 1'b1;
      end
      build_flow(kind);
      for (int j = 0; j < flow_q.size(); j++)
        offer(flow_q[j], j == 0,
              (j == flow_q.size() - 1) ? ($urandom_range(0, 1) == 1)
                                       : ($urandom_range(0, 11) == 0));
      flows_sent++;
      idx++;
      if (idx == 5) idle_until_drained();
    end

    idle_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d flows, %0d payload bytes, every flow shape and a receiver hold-off",
             flows_sent, sent_bytes);
    $display("result words: name %0d, last %0d, empty %0d, failed %0d, undecided %0d",
             words_by_status[ST_NAME], words_by_status[ST_NAME_LAST],
             words_by_status[ST_EMPTY], words_by_status[ST_FAIL],
             words_by_status[ST_UNDECIDED]);
    if (err_count == 0) begin
      $display("tls_client_hello_sni_parser_tb passed");
    end else begin
      $display("tls_client_hello_sni_parser_tb failed");
    end
    $finish;
  end

endmodule
